FILE: sv/ddo_pkg.sv
package ddo_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int NUM_ITER = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int ITER_W = $clog2(NUM_ITER + 1);
   localparam logic signed [33:0] CORDIC_K = 34'sd652032874;

   localparam logic [2:0] REG_TIME_STEP = 3'd0;
   localparam logic [2:0] REG_TURN_GAIN = 3'd1;
   localparam logic [2:0] REG_START_X = 3'd2;
   localparam logic [2:0] REG_START_Y = 3'd3;
   localparam logic [2:0] REG_START_HEADING = 3'd4;

   localparam logic [15:0] RST_TIME_STEP = 16'd1092;
   localparam logic [23:0] RST_TURN_GAIN = 24'd89006;

   typedef struct packed {
      logic signed [15:0] left_speed;
      logic signed [15:0] right_speed;
      logic signed [15:0] left_offset;
      logic signed [15:0] right_offset;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0] heading_out;
   } rsp_type;

   typedef struct packed {
      logic [2:0] index;
      logic [31:0] data;
   } csr_type;

   // classified tick: twice the centre travel and half the turn
   typedef struct packed {
      logic signed [18:0] sum;
      logic [15:0] half;
   } move_type;

   typedef enum logic [2:0] {
      FE_IDLE, FE_TRAVEL, FE_TURN, FE_PUSH
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE, BE_TURN1, BE_ROT, BE_MULX, BE_MULY, BE_SUM, BE_OUT
   } be_state_type;

   function automatic logic signed [33:0] atan_of(input logic [4:0] i);
      logic signed [33:0] r;
      unique case (i)
         5'd0: r = 34'sh20000000;
         5'd1: r = 34'sh12E4051E;
         5'd2: r = 34'sh09FB385B;
         5'd3: r = 34'sh051111D4;
         5'd4: r = 34'sh028B0D43;
         5'd5: r = 34'sh0145D7E1;
         5'd6: r = 34'sh00A2F61E;
         5'd7: r = 34'sh00517C55;
         5'd8: r = 34'sh0028BE53;
         5'd9: r = 34'sh00145F2F;
         5'd10: r = 34'sh000A2F98;
         5'd11: r = 34'sh000517CC;
         5'd12: r = 34'sh00028BE6;
         5'd13: r = 34'sh000145F3;
         5'd14: r = 34'sh0000A2F9;
         5'd15: r = 34'sh0000517D;
         5'd16: r = 34'sh000028BE;
         5'd17: r = 34'sh0000145F;
         5'd18: r = 34'sh00000A2F;
         5'd19: r = 34'sh00000517;
         5'd20: r = 34'sh0000028B;
         5'd21: r = 34'sh00000145;
         5'd22: r = 34'sh000000A2;
         5'd23: r = 34'sh00000051;
         default: r = 34'sd0;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/ddo_if.sv
interface ddo_req_if import ddo_pkg::*; ();
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ddo_rsp_if import ddo_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ddo_csr_if import ddo_pkg::*; ();
   logic valid;
   logic ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: sv/differential_drive_odometry.sv
// channel  ports  dir   payload
// req      req_*  in    left/right speed, left/right offset
// rsp      rsp_*  out   pos_x, pos_y, heading_out
// csr      csr_*  in    register index, write data
// a request beat passes the front (accept, travel, turn, push), then the queue, then the back:
// pop, turn, 16 cordic steps, two multiplies, sum and output set the result beat
// the back takes a new tick only when done with the last one, and so does the front
// a two-entry queue lets the front take the next tick while the back works
// reset restores registers and zeroes the pose; the result register holds a
// beat until taken, csr is always ready
module differential_drive_odometry import ddo_pkg::*; (
   input logic clock,
   input logic reset,
   ddo_req_if.sink req,
   ddo_rsp_if.source rsp,
   ddo_csr_if.sink csr
);

   logic [15:0] time_step_ff;
   logic [23:0] turn_gain_ff;
   logic push, full, pop, empty;
   move_type push_data, pop_data;
   logic wr;

   assign csr.ready = 1'b1;
   assign wr = csr.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= RST_TIME_STEP;
         turn_gain_ff <= RST_TURN_GAIN;
      end else if (wr) begin
         if (csr.data.index == REG_TIME_STEP) time_step_ff <= csr.data.data[15:0];
         if (csr.data.index == REG_TURN_GAIN) turn_gain_ff <= csr.data.data[23:0];
      end
   end

   ddo_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .time_step(time_step_ff), .turn_gain(turn_gain_ff),
      .push(push), .push_data(push_data), .full(full)
   );

   ddo_queue u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data), .full(full),
      .pop(pop), .empty(empty), .pop_data(pop_data)
   );

   ddo_back u_back (
      .clock(clock), .reset(reset), .pop_empty(empty), .pop_data(pop_data), .pop(pop),
      .rsp(rsp),
      .load_x(wr && csr.data.index == REG_START_X),
      .load_y(wr && csr.data.index == REG_START_Y),
      .load_h(wr && csr.data.index == REG_START_HEADING),
      .load_value(csr.data.data)
   );

endmodule

FILE: sv/ddo_front.sv
module ddo_front import ddo_pkg::*; (
   input logic clock,
   input logic reset,
   ddo_req_if.sink req,
   input logic [15:0] time_step,
   input logic [23:0] turn_gain,
   output logic push,
   output move_type push_data,
   input logic full
);

   fe_state_type state_ff, state_in;
   req_type item_ff, item_in;
   logic signed [17:0] lt_ff, lt_in, rt_ff, rt_in;
   move_type mv_ff, mv_in;

   logic signed [32:0] lp, rp;
   logic signed [18:0] diff;
   logic signed [43:0] tp;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FE_IDLE;
      else state_ff <= state_in;
      item_ff <= item_in;
      lt_ff <= lt_in;
      rt_ff <= rt_in;
      mv_ff <= mv_in;
   end

   always_comb begin
      lp = item_ff.left_speed * $signed({1'b0, time_step}) + 33'sd32768;
      rp = item_ff.right_speed * $signed({1'b0, time_step}) + 33'sd32768;
      diff = 19'(lt_ff) - 19'(rt_ff);
      tp = diff * $signed({1'b0, turn_gain}) + 44'sd65536;
      state_in = state_ff;
      item_in = item_ff;
      lt_in = lt_ff;
      rt_in = rt_ff;
      mv_in = mv_ff;
      req.ready = 1'b0;
      push = 1'b0;
      push_data = mv_ff;
      unique case (state_ff)
         FE_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               item_in = req.data;
               state_in = FE_TRAVEL;
            end
         end
         FE_TRAVEL: begin
            lt_in = 18'(lp >>> 16) + 18'(item_ff.left_offset);
            rt_in = 18'(rp >>> 16) + 18'(item_ff.right_offset);
            state_in = FE_TURN;
         end
         FE_TURN: begin
            mv_in.sum = 19'(lt_ff) + 19'(rt_ff);
            mv_in.half = tp[32:17];
            state_in = FE_PUSH;
         end
         FE_PUSH: begin
            if (!full) begin
               push = 1'b1;
               state_in = FE_IDLE;
            end
         end
         default: state_in = FE_IDLE;
      endcase
   end

endmodule

FILE: sv/ddo_queue.sv
module ddo_queue import ddo_pkg::*; (
   input logic clock,
   input logic reset,
   input logic push,
   input move_type push_data,
   output logic full,
   input logic pop,
   output logic empty,
   output move_type pop_data
);

   move_type slot_ff [2];
   logic wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full = (cnt_ff == 2'd2);
   assign empty = (cnt_ff == 2'd0);
   assign pop_data = slot_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push && !full) wp_ff <= ~wp_ff;
         if (pop && !empty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
      end
      if (push && !full) slot_ff[wp_ff] <= push_data;
   end

`ifndef SYNTH
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      full |=> cnt_ff <= 2'd2) else $error("queue overflow");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (push && !full && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("queue count");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      empty |-> wp_ff == rp_ff) else $error("queue pointers");
`endif

endmodule

FILE: sv/ddo_back.sv
module ddo_back import ddo_pkg::*; (
   input logic clock,
   input logic reset,
   input logic pop_empty,
   input move_type pop_data,
   output logic pop,
   ddo_rsp_if.source rsp,
   input logic load_x,
   input logic load_y,
   input logic load_h,
   input logic [31:0] load_value
);

   be_state_type state_ff, state_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic [15:0] ph_ff, ph_in;
   move_type mv_ff, mv_in;
   logic flip_ff, flip_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [ITER_W-1:0] it_ff, it_in;
   logic signed [52:0] m_ff, m_in;
   logic signed [32:0] dx_ff, dx_in;
   rsp_type out_ff, out_in;
   logic ov_ff, ov_in;

   logic [15:0] hnew;
   logic [31:0] u;
   logic signed [33:0] xs, ys, cs;
   logic signed [33:0] sx, sy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
         ov_ff <= 1'b0;
         px_ff <= '0;
         py_ff <= '0;
         ph_ff <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         px_ff <= px_in;
         py_ff <= py_in;
         ph_ff <= ph_in;
      end
      mv_ff <= mv_in;
      flip_ff <= flip_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      it_ff <= it_in;
      m_ff <= m_in;
      dx_ff <= dx_in;
      out_ff <= out_in;
   end

   assign rsp.valid = ov_ff;
   assign rsp.data = out_ff;

   function automatic logic signed [31:0] sat(input logic signed [33:0] v);
      if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -34'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      px_in = px_ff;
      py_in = py_ff;
      ph_in = ph_ff;
      mv_in = mv_ff;
      flip_in = flip_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      it_in = it_ff;
      m_in = m_ff;
      dx_in = dx_ff;
      out_in = out_ff;
      ov_in = ov_ff;
      pop = 1'b0;
      hnew = ph_ff + mv_ff.half;
      u = {hnew, 16'd0};
      xs = x_ff >>> it_ff;
      ys = y_ff >>> it_ff;
      cs = flip_ff ? -x_ff : x_ff;
      sx = flip_ff ? -y_ff : y_ff;
      sy = 34'(px_ff) + 34'(dx_ff);
      if (ov_ff && rsp.ready) ov_in = 1'b0;
      unique case (state_ff)
         BE_IDLE: begin
            if (!pop_empty) begin
               pop = 1'b1;
               mv_in = pop_data;
               state_in = BE_TURN1;
            end
         end
         BE_TURN1: begin
            ph_in = hnew;
            flip_in = u[31] ^ u[30];
            x_in = CORDIC_K;
            y_in = '0;
            z_in = 34'($signed(u ^ {(u[31] ^ u[30]), 31'd0}));
            it_in = '0;
            state_in = BE_ROT;
         end
         BE_ROT: begin
            if (z_ff >= 0) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_of(5'(it_ff));
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_of(5'(it_ff));
            end
            it_in = it_ff + 1'b1;
            if (it_ff == ITER_W'(NUM_ITER - 1)) state_in = BE_MULX;
         end
         BE_MULX: begin
            m_in = mv_ff.sum * cs + 53'sh40000000;
            state_in = BE_MULY;
         end
         BE_MULY: begin
            dx_in = 33'(m_ff >>> 31);
            m_in = mv_ff.sum * sx + 53'sh40000000;
            state_in = BE_SUM;
         end
         BE_SUM: begin
            px_in = sat(sy);
            py_in = sat(34'(py_ff) + 34'(m_ff >>> 31));
            ph_in = hnew;
            state_in = BE_OUT;
         end
         BE_OUT: begin
            if (!ov_ff || rsp.ready) begin
               out_in.pos_x = px_ff;
               out_in.pos_y = py_ff;
               out_in.heading_out = ph_ff;
               ov_in = 1'b1;
               state_in = BE_IDLE;
            end
         end
         default: state_in = BE_IDLE;
      endcase
      if (load_x) px_in = load_value;
      if (load_y) py_in = load_value;
      if (load_h) ph_in = load_value[15:0];
   end

`ifndef SYNTH
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> !pop_empty && state_ff == BE_IDLE) else $error("pop while busy");
   a_rot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BE_TURN1) |=> state_ff == BE_ROT && it_ff == '0) else $error("rotation start");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp.ready) |=> ov_ff && $stable(out_ff)) else $error("result lost");
`endif

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
module tb_top import ddo_pkg::*; ();

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddo_req_if req_if ();
   ddo_rsp_if rsp_if ();
   ddo_csr_if csr_if ();

   differential_drive_odometry u_top (
      .clock(clock),
      .reset(reset),
      .req(req_if.sink),
      .rsp(rsp_if.source),
      .csr(csr_if.sink)
   );

   always #1 clock = ~clock;

   // odometry state and registers of the predictor
   logic [15:0] m_time_step;
   logic [23:0] m_turn_gain;
   logic signed [31:0] m_start_x, m_start_y;
   logic [15:0] m_start_heading;
   logic signed [63:0] m_x, m_y;
   logic [15:0] m_heading;

   rsp_type pose_queue[$];
   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;
   int quiet_cycles = 0;
   bit timed_out = 0;

   localparam int QUIET_LIMIT = 20000;
   localparam logic [2:0] REG_UNUSED = 3'd7;

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic logic [63:0] atan_entry(input int i);
      logic [31:0] tbl[24];
      tbl = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
              32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
      return {32'b0, tbl[i]};
   endfunction

   task automatic sin_cos(input logic [15:0] hd, output logic signed [63:0] c,
                          output logic signed [63:0] s);
      logic [31:0] u;
      logic flip;
      logic signed [63:0] x, y, z, xs, ys;
      u = {hd, 16'h0};
      flip = u[31] ^ u[30];
      x = 64'sd652032874;
      y = 0;
      if (flip) u = u + 32'h80000000;
      z = {{32{u[31]}}, u};
      for (int i = 0; i < NUM_ITER; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - $signed(atan_entry(i));
         end else begin
            x = x + ys; y = y - xs; z = z + $signed(atan_entry(i));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endtask

   task automatic predict_pose(input req_type t);
      logic signed [63:0] lt, rt, sum, half, c, s;
      rsp_type r;
      lt = (($signed({{48{t.left_speed[15]}}, t.left_speed}) * $signed({48'b0, m_time_step})
            + 32768) >>> 16) + t.left_offset;
      rt = (($signed({{48{t.right_speed[15]}}, t.right_speed}) * $signed({48'b0, m_time_step})
            + 32768) >>> 16) + t.right_offset;
      sum = lt + rt;
      half = ((lt - rt) * $signed({40'b0, m_turn_gain}) + 65536) >>> 17;
      m_heading = m_heading + half[15:0];
      sin_cos(m_heading, c, s);
      m_x = sat32(m_x + ((sum * c + 64'sh40000000) >>> 31));
      m_y = sat32(m_y + ((sum * s + 64'sh40000000) >>> 31));
      m_heading = m_heading + half[15:0];
      r.pos_x = m_x[31:0];
      r.pos_y = m_y[31:0];
      r.heading_out = m_heading;
      pose_queue.insert(pose_queue.size(), r);
   endtask

   task automatic model_reset();
      m_time_step = RST_TIME_STEP;
      m_turn_gain = RST_TURN_GAIN;
      m_start_x = 0; m_start_y = 0; m_start_heading = 0;
      m_x = 0; m_y = 0; m_heading = 0;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_if.valid <= 1'b1;
      csr_if.data <= '{index: idx, data: val};
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         REG_TIME_STEP: m_time_step = val[15:0];
         REG_TURN_GAIN: m_turn_gain = val[23:0];
         REG_START_X: begin m_start_x = val; m_x = $signed(val); end
         REG_START_Y: begin m_start_y = val; m_y = $signed(val); end
         REG_START_HEADING: begin m_start_heading = val[15:0]; m_heading = val[15:0]; end
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_tick(input req_type t);
      while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clock);
      req_if.valid <= 1'b1;
      req_if.data <= t;
      do @(posedge clock); while (!req_if.ready);
      predict_pose(t);
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic req_type rand_tick(input bit wide);
      req_type t;
      t = {$urandom, $urandom};
      if (!wide) begin
         t.left_speed = 16'($signed($urandom_range(2048)) - 1024);
         t.right_speed = 16'(t.left_speed + $signed($urandom_range(256)) - 128);
         t.left_offset = 16'($signed($urandom_range(64)) - 32);
         t.right_offset = 16'($signed($urandom_range(64)) - 32);
      end
      if ($urandom_range(9) == 0) t = {$urandom, $urandom};
      return t;
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pose_queue.size() == 0) begin
               report("unexpected beat", 0, 0);
            end else begin
               rsp_type w;
               w = pose_queue.pop_front();
               if (rsp_if.data.pos_x !== w.pos_x) report("pos_x", rsp_if.data.pos_x, w.pos_x);
               if (rsp_if.data.pos_y !== w.pos_y) report("pos_y", rsp_if.data.pos_y, w.pos_y);
               if (rsp_if.data.heading_out !== w.heading_out)
                  report("heading", rsp_if.data.heading_out, w.heading_out);
            end
         end
         rsp_if.ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || csr_if.valid
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      logic [15:0] ext[4];
      ext = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++)
            send_tick('{ext[i], ext[j], ext[(i + j) % 4], ext[(i + 2 * j) % 4]});
      drain();
      write_reg(REG_START_HEADING, 32'h4000);
      for (int i = 0; i < 4; i++) send_tick('{16'h0100, 16'h0100, 16'h0000, 16'h0000});
      drain();
   endtask

   task automatic test_saturation();
      write_reg(REG_TIME_STEP, 32'hFFFF);
      write_reg(REG_TURN_GAIN, 32'h0);
      write_reg(REG_START_X, 32'h7FFFFF00);
      write_reg(REG_START_Y, 32'h80000100);
      write_reg(REG_START_HEADING, 32'h2000);
      write_reg(REG_UNUSED, 32'hFFFFFFFF);
      for (int i = 0; i < 4; i++) send_tick('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
      drain();
      write_reg(REG_START_HEADING, 32'hA000);
      for (int i = 0; i < 4; i++) send_tick('{16'h8000, 16'h8000, 16'h8000, 16'h8000});
      drain();
   endtask

   task automatic test_random(input int count);
      logic [2:0] idx;
      for (int i = 0; i < count; i++) begin
         if (i % 70 == 69) begin
            drain();
            write_reg(REG_TIME_STEP, $urandom_range(3) == 0 ? 32'h0 : $urandom);
            write_reg(REG_TURN_GAIN, $urandom_range(3) == 0 ? 32'hFFFFFF : $urandom_range(200000));
            idx = 3'($urandom_range(REG_START_HEADING, REG_START_X));
            write_reg(idx, $urandom);
         end
         send_tick(rand_tick($urandom_range(4) == 0));
      end
      drain();
   endtask

   initial begin
      model_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_saturation();
      model_reset();
      write_reg(REG_TIME_STEP, RST_TIME_STEP);
      write_reg(REG_TURN_GAIN, RST_TURN_GAIN);
      write_reg(REG_START_X, 32'h0);
      write_reg(REG_START_Y, 32'h0);
      write_reg(REG_START_HEADING, 32'h0);
      send_idle = 30; recv_idle = 83;
      test_random(270);
      send_idle = 83; recv_idle = 30;
      test_random(270);
      send_idle = 0; recv_idle = 0;
      test_random(270);
      if (errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
